>>> hw/rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = AW + 1;
    localparam int DW    = 32;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_DUMP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic [DW-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic [CW-1:0]   count;
        logic            dump_busy;
    } occ_t;

    // base + off, folded back into the ring; base < DEPTH and off <= DEPTH
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_dec(logic [AW-1:0] base);
        logic [AW-1:0] res;
        if (base == '0)
        begin
            res = AW'(DEPTH - 1);
        end
        else
        begin
            res = base - 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/deq_front.sv
`default_nettype none

module deq_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire logic [2:0]           action,
    input  wire logic signed [31:0]   value,
    output logic                      head_valid,
    output deq_pkg::cmd_t             head,
    input  wire logic                 head_pop
);
    import deq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       keep;
    cmd_kind_t  kind;
    logic       push;
    logic       pop;

    // classify; unused codes are taken and dropped
    always_comb
    begin
        keep = 1'b1;
        kind = CMD_DUMP;
        unique case (action)
            ACT_PUSH_FRONT: kind = CMD_PUSH_FRONT;
            ACT_PUSH_BACK:  kind = CMD_PUSH_BACK;
            ACT_POP_FRONT:  kind = CMD_POP_FRONT;
            ACT_POP_BACK:   kind = CMD_POP_BACK;
            ACT_DUMP:       kind = CMD_DUMP;
            default:        keep = 1'b0;
        endcase
    end

    assign cmd_ready  = (fill_reg != 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    assign push = cmd_valid && cmd_ready && keep;
    assign pop  = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{kind: kind, value: value};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/deq_back.sv
`default_nettype none

module deq_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire deq_pkg::cmd_t      head,
    output logic                    head_pop,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic [1:0]              status,
    output logic signed [31:0]      element,
    output logic                    last,
    output deq_pkg::occ_t           occ
);
    import deq_pkg::*;

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_last_reg;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg;
    logic [DW-1:0] out_element_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          move_pend;
    logic          slot_free;
    logic          is_dump;
    logic          is_empty;
    logic          is_full;
    logic          exec_single;
    logic          issue_rd;
    logic          dump_end;
    logic [1:0]    res_status;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign move_pend = rd_pend_reg && out_free;
    // the RAM read register is the pending slot; it frees as it moves on
    assign slot_free = !rd_pend_reg || out_free;
    assign is_dump   = (head.kind == CMD_DUMP);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));

    assign exec_single = head_valid && (!is_dump || is_empty) && out_free && !rd_pend_reg;
    assign issue_rd    = head_valid && is_dump && !is_empty && slot_free;
    assign dump_end    = issue_rd && ((idx_reg + 1'b1) == count_reg);
    assign head_pop    = exec_single || dump_end;
    assign rd_addr     = wrap_add(front_reg, idx_reg);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        res_status = ST_OK;
        wr_en      = 1'b0;
        wr_addr    = wrap_add(front_reg, count_reg);
        if (exec_single)
        begin
            unique case (head.kind)
                CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        front_next = wrap_dec(front_reg);
                        wr_addr    = front_next;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        front_next = wrap_add(front_reg, CW'(1));
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    // dump of an empty store
                    res_status = ST_EMPTY;
                end
            endcase
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (dump_end)
        begin
            idx_next = '0;
        end
        else if (issue_rd)
        begin
            idx_next = idx_reg + 1'b1;
        end

        rd_pend_next = rd_pend_reg;
        if (issue_rd)
        begin
            rd_pend_next = 1'b1;
        end
        else if (move_pend)
        begin
            rd_pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (exec_single || move_pend)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_rd)
        begin
            rd_last_reg <= dump_end;
        end
        if (exec_single)
        begin
            out_status_reg  <= res_status;
            out_element_reg <= '0;
            out_last_reg    <= 1'b1;
        end
        else if (move_pend)
        begin
            out_status_reg  <= ST_OK;
            out_element_reg <= rd_data;
            out_last_reg    <= rd_last_reg;
        end
    end

    deq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (head.value),
        .rd_en   (issue_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rsp_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign element       = $signed(out_element_reg);
    assign last          = out_last_reg;
    assign occ.count     = count_reg;
    assign occ.dump_busy = (idx_reg != '0);

endmodule

`default_nettype wire

>>> hw/rtl/double_ended_queue_core.sv
// Channel   Handshake              Fields
// command   cmd_valid / cmd_ready  action[2:0], value[31:0] signed
// response  rsp_valid / rsp_ready  status[1:0], element[31:0] signed, last
//
// Push, pop and empty dump run at one word per cycle while rsp_ready is high. A
// dump sends one stored element per cycle through the single RAM read port, as long
// as rsp_ready is high; the next command waits until the dump's last read drains.
// Responses leave an output register; dump words first pass the RAM read register.
// Reset clears pointers and count at once; the store itself is not cleared.
// A two-word queue fills while rsp_ready stalls; unused codes drop.
`default_nettype none

module double_ended_queue_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire logic [2:0]          action,
    input  wire logic signed [31:0]  value,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [1:0]               status,
    output logic signed [31:0]       element,
    output logic                     last
);
    import deq_pkg::*;

    logic head_valid;
    cmd_t head;
    logic head_pop;
    occ_t occ;

    deq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .action     (action),
        .value      (value),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    deq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .element    (element),
        .last       (last),
        .occ        (occ)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ.count <= CW'(DEPTH))
        else $error("element count beyond depth");

    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> last && element == '0)
        else $error("failed command not a single zero word");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> occ.count == '0)
        else $error("empty status with elements held");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> occ.count == CW'(DEPTH))
        else $error("full status with room left");

    a_dump_head: assert property (@(posedge clk) disable iff (!rst_n)
        occ.dump_busy |-> head_valid && head.kind == CMD_DUMP)
        else $error("dump index held with no dump at the head");

endmodule

`default_nettype wire
